>>> src/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define CHK_PROP_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/ufas_pkg.sv
// Shared constants, types and helpers for the unpacked float arithmetic core.
// No dependencies.
package ufas_pkg;

  localparam int FB = 32;            // significand bits in use
  localparam int LZW = $clog2(FB);   // leading-zero count width
  localparam int EW = 12;            // result exponent width
  localparam int IEW = 11;           // operand exponent width
  localparam int PFW = 32;           // fraction port width

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // One pipeline slot. For add/sub, kind is the effective magnitude operation.
  typedef struct packed {
    logic                 valid;
    op_t                  kind;
    logic                 neg;
    logic                 zero;
    logic signed [EW-1:0] exp;
    logic [FB-1:0]        acc;   // significand, later quotient bits
    logic [FB-1:0]        rem;   // aligned operand or division remainder
    logic [FB-1:0]        dvs;   // divisor
    logic [LZW-1:0]       lz;    // normalization shift
  } stage_t;

  function automatic logic [LZW-1:0] lzc(input logic [FB-1:0] v);
    logic [LZW-1:0] n;
    logic           found;
    n = '0;
    found = 1'b0;
    for (int i = FB - 1; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 1'b1;
      end
    end
    return n;
  endfunction

endpackage

>>> src/ufas_front.sv
// Front end: operand decode and ordering, then alignment, multiply and divide setup.
// Depends on ufas_pkg.
module ufas_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    req_type,
  input  logic                          a_neg,
  input  logic signed [ufas_pkg::IEW-1:0] a_exp,
  input  logic [ufas_pkg::PFW-1:0]      a_frac,
  input  logic                          b_neg,
  input  logic signed [ufas_pkg::IEW-1:0] b_exp,
  input  logic [ufas_pkg::PFW-1:0]      b_frac,
  output ufas_pkg::stage_t              s2
);
  import ufas_pkg::*;

  logic signed [EW-1:0] ae, be;
  logic [FB-1:0]        fa, fb, sa, sb;
  logic                 a_big;
  op_t                  op;

  op_t                  kind_n;
  logic                 neg_n;
  logic signed [EW-1:0] exp_n;
  logic [FB-1:0]        big_n, small_n;
  logic [EW-1:0]        shift_n;

  logic                 s1_valid;
  op_t                  s1_kind;
  logic                 s1_neg;
  logic signed [EW-1:0] s1_exp;
  logic [FB-1:0]        s1_big, s1_small;
  logic [EW-1:0]        s1_shift;

  logic [2*FB-1:0]      prod;
  logic [FB-1:0]        yd;
  stage_t               s2_next;

  always_comb begin
    ae = EW'(a_exp);
    be = EW'(b_exp);
    fa = a_frac[FB-1:0];
    fb = b_frac[FB-1:0];
    sa = {1'b1, fa[FB-1:1]};
    sb = {1'b1, fb[FB-1:1]};
    a_big = (ae > be) || ((ae == be) && (fa > fb));
    op = op_t'(req_type);

    kind_n  = op;
    neg_n   = a_neg;
    exp_n   = a_big ? ae : be;
    big_n   = a_big ? sa : sb;
    small_n = a_big ? sb : sa;
    shift_n = a_big ? EW'(ae - be) : EW'(be - ae);
    unique case (op)
      OP_ADD: kind_n = (a_neg == b_neg) ? OP_ADD : OP_SUB;
      OP_SUB: kind_n = (a_neg == b_neg) ? OP_SUB : OP_ADD;
      OP_MUL, OP_DIV: begin
        neg_n   = a_neg ^ b_neg;
        exp_n   = (op == OP_MUL) ? ae + be + EW'(1) : ae - be;
        big_n   = sa;
        small_n = sb;
        shift_n = '0;
      end
      default: kind_n = op;
    endcase
    // magnitude subtract flips the sign when b is the larger
    if (kind_n == OP_SUB && !a_big) neg_n = !a_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind  <= kind_n;
      s1_neg   <= neg_n;
      s1_exp   <= exp_n;
      s1_big   <= big_n;
      s1_small <= small_n;
      s1_shift <= shift_n;
    end
  end

  always_comb begin
    prod = s1_big * s1_small;
    yd = (s1_big < s1_small) ? (s1_small >> 1) : s1_small;
    s2_next.valid = s1_valid;
    s2_next.kind  = s1_kind;
    s2_next.neg   = s1_neg;
    s2_next.zero  = 1'b0;
    s2_next.exp   = s1_exp;
    s2_next.acc   = s1_big;
    s2_next.rem   = s1_small >> s1_shift;  // shift at or past width gives zero
    s2_next.dvs   = '0;
    s2_next.lz    = '0;
    unique case (s1_kind)
      OP_ADD, OP_SUB: ;
      OP_MUL: begin
        s2_next.acc = prod[2*FB-1:FB];
        s2_next.rem = '0;
      end
      OP_DIV: begin
        if (s1_big < s1_small) s2_next.exp = s1_exp - EW'(1);
        s2_next.acc = '0;
        s2_next.rem = s1_big - yd;
        s2_next.dvs = yd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s2.valid <= 1'b0;
    else if (en) s2 <= s2_next;
  end

endmodule

>>> src/ufas_arith.sv
// Magnitude add/subtract, quotient integer-part fixup, then leading-zero count.
// Depends on ufas_pkg.
module ufas_arith (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ufas_pkg::stage_t s2,
  output ufas_pkg::stage_t s4
);
  import ufas_pkg::*;

  logic [FB:0]    sum;
  logic [LZW-1:0] lzv;
  stage_t         s3, s3_next, s4_next;

  always_comb begin
    sum = {1'b0, s2.acc} + {1'b0, s2.rem};
    s3_next = s2;
    unique case (s2.kind)
      OP_ADD: begin
        if (sum[FB]) begin
          s3_next.exp = s2.exp + EW'(1);
          s3_next.acc = sum[FB:1];
        end else begin
          s3_next.acc = sum[FB-1:0];
        end
      end
      OP_SUB: begin
        s3_next.acc  = s2.acc - s2.rem;
        s3_next.zero = (s2.acc == s2.rem);
      end
      OP_MUL: ;
      OP_DIV: begin
        // remainder may still hold one divisor when dividend is exactly twice it
        if (s2.rem >= s2.dvs) s3_next.rem = s2.rem - s2.dvs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s3.valid <= 1'b0;
    else if (en) s3 <= s3_next;
  end

  always_comb begin
    lzv = lzc(s3.acc);
    s4_next = s3;
    if (s3.kind != OP_DIV) begin
      s4_next.lz  = lzv;
      s4_next.exp = s3.exp - EW'(lzv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s4.valid <= 1'b0;
    else if (en) s4 <= s4_next;
  end

endmodule

>>> src/ufas_dstep.sv
// One restoring-division step: one quotient bit per stage; other ops pass through.
// Depends on ufas_pkg.
module ufas_dstep (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ufas_pkg::stage_t d_in,
  output ufas_pkg::stage_t d_out
);
  import ufas_pkg::*;

  logic [FB:0] r2;
  logic        q;
  stage_t      d_next;

  always_comb begin
    r2 = {d_in.rem, 1'b0};
    q = (r2 >= {1'b0, d_in.dvs});
    d_next = d_in;
    if (d_in.kind == OP_DIV) begin
      d_next.rem = q ? FB'(r2 - {1'b0, d_in.dvs}) : r2[FB-1:0];
      d_next.acc = {d_in.acc[FB-2:0], q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_out.valid <= 1'b0;
    else if (en) d_out <= d_next;
  end

endmodule

>>> src/unpacked_float_add_sub_mul_div_core.sv
// Unpacked float add/sub/mul/div core, top level.
// 37 register stages: 4 ahead of the divide steps, 32 divide-step stages and
// 1 output stage, which drives out_valid. All ops share the same pipeline.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken. Sync reset clears all valid bits.
module unpacked_float_add_sub_mul_div_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic                            a_neg,
  input  logic signed [ufas_pkg::IEW-1:0] a_exp,
  input  logic [ufas_pkg::PFW-1:0]        a_frac,
  input  logic                            b_neg,
  input  logic signed [ufas_pkg::IEW-1:0] b_exp,
  input  logic [ufas_pkg::PFW-1:0]        b_frac,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            r_neg,
  output logic signed [ufas_pkg::EW-1:0]  r_exp,
  output logic [ufas_pkg::PFW-1:0]        r_frac,
  output logic                            r_zero
);
  import ufas_pkg::*;

  logic          en;
  stage_t        s2, s4, last;
  stage_t        chain [0:FB];
  logic [FB-1:0] shifted, frac_n;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  ufas_front u_front (
    .clk, .rst, .en, .in_valid, .req_type,
    .a_neg, .a_exp, .a_frac, .b_neg, .b_exp, .b_frac,
    .s2
  );

  ufas_arith u_arith (.clk, .rst, .en, .s2, .s4);

  assign chain[0] = s4;
  for (genvar i = 0; i < FB; i++) begin : gen_step
    ufas_dstep u_step (.clk, .rst, .en, .d_in(chain[i]), .d_out(chain[i+1]));
  end
  assign last = chain[FB];

  always_comb begin
    shifted = last.acc << last.lz;
    frac_n = (last.kind == OP_DIV) ? last.acc : {shifted[FB-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= last.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_zero <= last.zero;
      r_neg  <= last.zero ? 1'b0 : last.neg;
      r_exp  <= last.zero ? '0 : last.exp;
      r_frac <= last.zero ? '0 : PFW'(frac_n);
    end
  end

endmodule

>>> src/ufas_checker.sv
// Port-level checker for the unpacked float core, bound to the top level.
// Depends on assert_macros.svh and ufas_pkg.
`include "assert_macros.svh"
module ufas_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            r_neg,
  input logic signed [ufas_pkg::EW-1:0]  r_exp,
  input logic [ufas_pkg::PFW-1:0]        r_frac,
  input logic                            r_zero
);

  `CHK_PROP(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CHK_PROP(a_zero_clean, out_valid && r_zero |-> !r_neg && r_exp == '0 && r_frac == '0,
            "zero result carries nonzero fields")
  `CHK_PROP(a_in_ready, in_ready == (!out_valid || out_ready),
            "input ready does not follow output stall")
  `CHK_PROP_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule

bind unpacked_float_add_sub_mul_div_core ufas_checker u_chk (.*);
